[rtl/rtvs_pkg.sv]
// Shared types, constants and tables of the relay tap voltage stabilizer.
package rtvs_pkg;

    // Measurement geometry.
    localparam int WINDOW_SAMPLES = 190;
    localparam int WINDOWS        = 3;

    // Field widths.
    localparam int SAMPLE_W   = 10;
    localparam int CFG_W      = 10;
    localparam int WAIT_W     = 16;
    localparam int TARGET_W   = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int SAMPLE_MAX = 2 ** SAMPLE_W - 1;
    localparam int COUNT_W    = $clog2(WINDOW_SAMPLES + 1);
    localparam int INDEX_W    = $clog2(WINDOWS + 1);
    localparam int SUM_W      = $clog2(WINDOWS * SAMPLE_MAX + 1);

    // A voltage is the window mean minus this offset.
    localparam int VOLT_OFFSET = 432;
    localparam int LIMIT_W     = $clog2(WINDOWS * (SAMPLE_MAX + VOLT_OFFSET) + 1);

    // Division by a small constant through a rounded-up reciprocal.
    localparam int RECIP_SHIFT = 13;
    localparam int WIN_RECIP   = (2 ** RECIP_SHIFT + WINDOWS - 1) / WINDOWS;
    localparam int SAFE_DIV    = 3;
    localparam int SAFE_RECIP  = (2 ** RECIP_SHIFT + SAFE_DIV - 1) / SAFE_DIV;
    localparam int PROD_W      = SUM_W + RECIP_SHIFT + 1;

    // Tap selection.
    localparam int TAP_STEP   = 20;
    localparam int TAP_MAX    = 5;
    localparam int NUM_RELAYS = 3;
    localparam logic [2:0] TAP_MAP [0:TAP_MAX] = '{3'd0, 3'd1, 3'd4, 3'd5, 3'd2, 3'd3};
    localparam logic [1:0] RELAY_ORDER [0:NUM_RELAYS-1] = '{2'd1, 2'd0, 2'd2};
    localparam logic [NUM_RELAYS-1:0] RELAY_RESET = 3'b010;

    // Action slots of one completed measurement: two LED or output slots,
    // then one turn-on pass and one turn-off pass over the relays.
    localparam int SLOTS  = 2 + 2 * NUM_RELAYS;
    localparam int SLOT_W = $clog2(SLOTS);

    // Action targets.
    localparam logic [TARGET_W-1:0] TGT_OUTPUT    = 3'd3;
    localparam logic [TARGET_W-1:0] TGT_DELAY_LED = 3'd4;
    localparam logic [TARGET_W-1:0] TGT_PROT_LED  = 3'd5;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_INPUT_LIMIT      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BAND_HIGH        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BAND_LOW         = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TAP_BASE         = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SAFE_LIMIT       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BUTTON_THRESHOLD = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_MS          = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SETTLE_MS        = 3'd7;

    // Configuration reset values.
    localparam logic [CFG_W-1:0]  RST_INPUT_LIMIT      = 10'd259;
    localparam logic [CFG_W-1:0]  RST_BAND_HIGH        = 10'd243;
    localparam logic [CFG_W-1:0]  RST_BAND_LOW         = 10'd217;
    localparam logic [CFG_W-1:0]  RST_TAP_BASE         = 10'd140;
    localparam logic [CFG_W-1:0]  RST_SAFE_LIMIT       = 10'd248;
    localparam logic [CFG_W-1:0]  RST_BUTTON_THRESHOLD = 10'd350;
    localparam logic [WAIT_W-1:0] RST_HOLD_MS          = 16'd10000;
    localparam logic [CFG_W-1:0]  RST_SETTLE_MS        = 10'd50;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [CFG_W-1:0]  input_limit;
        logic [CFG_W-1:0]  band_high;
        logic [CFG_W-1:0]  band_low;
        logic [CFG_W-1:0]  tap_base;
        logic [CFG_W-1:0]  safe_limit;
        logic [CFG_W-1:0]  button_threshold;
        logic [WAIT_W-1:0] hold_ms;
        logic [CFG_W-1:0]  settle_ms;
    } cfg_t;

    typedef enum logic [1:0] {
        PH_IN,
        PH_OUT1,
        PH_OUT2
    } phase_t;

    typedef enum logic {
        JOB_CHECK,
        JOB_FINAL
    } job_kind_t;

    typedef struct packed {
        job_kind_t           kind;
        logic                in_ok;
        logic [SUM_W-1:0]    in_sum;
        logic [SUM_W-1:0]    out_sum;
        logic [SAMPLE_W-1:0] button_raw;
    } job_t;

    typedef struct packed {
        logic [TARGET_W-1:0] target;
        logic                level;
        logic [WAIT_W-1:0]   wait_ms;
    } action_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_PLAN,
        B_EMIT
    } back_state_t;

endpackage

[rtl/rtvs_in_if.sv]
// Sample channel: valid/ready handshake with the ADC reading as payload.
interface rtvs_in_if;
    logic                          valid;
    logic                          ready;
    logic [rtvs_pkg::SAMPLE_W-1:0] sample;
    logic                          channel;
    logic [rtvs_pkg::SAMPLE_W-1:0] button_raw;

    modport source (output valid, output sample, output channel, output button_raw,
                    input ready);
    modport sink (input valid, input sample, input channel, input button_raw,
                  output ready);
endinterface

[rtl/rtvs_out_if.sv]
// Action channel: valid/ready handshake with one relay or LED action as payload.
interface rtvs_out_if;
    logic                          valid;
    logic                          ready;
    logic [rtvs_pkg::TARGET_W-1:0] target;
    logic                          level;
    logic [rtvs_pkg::WAIT_W-1:0]   wait_ms;
    logic                          last;

    modport source (output valid, output target, output level, output wait_ms,
                    output last, input ready);
    modport sink (input valid, input target, input level, input wait_ms,
                  input last, output ready);
endinterface

[rtl/relay_tap_voltage_stabilizer_top.sv]
// Top level of the relay tap voltage stabilizer: configuration registers and wiring.
//
//  Channel  Direction  Handshake      Payload
//  adc      sink       valid/ready    sample[9:0], channel, button_raw[9:0]
//  act      source     valid/ready    target[2:0], level, wait_ms[15:0], last
//  cfg      write      cfg_we         cfg_index[2:0], cfg_data[15:0]
//
// The front end takes one sample transaction every clock while the job queue has
// room; samples for the channel that is not being measured are dropped.
// A finished output measurement reaches the action sequencer through a two-entry
// queue, then passes the job register, the action plan and the action register;
// after that one action leaves per clock while act is ready. A measurement yields
// at most five. The action register keeps the front end accepting samples while
// act stalls; the queue fills only when measurements complete faster than their
// actions drain. Reset is asynchronous and active low; it restores the control and
// configuration registers at once, with no clearing pass; payload registers are not.
module relay_tap_voltage_stabilizer_top (
    input  logic                                clk,
    input  logic                                rst_n,
    rtvs_in_if.sink                             adc,
    rtvs_out_if.source                          act,
    input  logic                                cfg_we,
    input  logic [rtvs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [rtvs_pkg::CFG_DATA_W-1:0]     cfg_data
);

    rtvs_pkg::cfg_t    cfg_reg, cfg_next;
    logic              q_push;
    logic              q_pop;
    logic              q_full;
    logic              q_empty;
    rtvs_pkg::job_t    q_in_job;
    rtvs_pkg::job_t    q_head;

    // Register writes; ten-bit registers keep the low bits of the data word.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                rtvs_pkg::REG_INPUT_LIMIT:
                    cfg_next.input_limit = cfg_data[rtvs_pkg::CFG_W-1:0];
                rtvs_pkg::REG_BAND_HIGH:
                    cfg_next.band_high = cfg_data[rtvs_pkg::CFG_W-1:0];
                rtvs_pkg::REG_BAND_LOW:
                    cfg_next.band_low = cfg_data[rtvs_pkg::CFG_W-1:0];
                rtvs_pkg::REG_TAP_BASE:
                    cfg_next.tap_base = cfg_data[rtvs_pkg::CFG_W-1:0];
                rtvs_pkg::REG_SAFE_LIMIT:
                    cfg_next.safe_limit = cfg_data[rtvs_pkg::CFG_W-1:0];
                rtvs_pkg::REG_BUTTON_THRESHOLD:
                    cfg_next.button_threshold = cfg_data[rtvs_pkg::CFG_W-1:0];
                rtvs_pkg::REG_HOLD_MS:
                    cfg_next.hold_ms = cfg_data[rtvs_pkg::WAIT_W-1:0];
                rtvs_pkg::REG_SETTLE_MS:
                    cfg_next.settle_ms = cfg_data[rtvs_pkg::CFG_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.input_limit      <= rtvs_pkg::RST_INPUT_LIMIT;
            cfg_reg.band_high        <= rtvs_pkg::RST_BAND_HIGH;
            cfg_reg.band_low         <= rtvs_pkg::RST_BAND_LOW;
            cfg_reg.tap_base         <= rtvs_pkg::RST_TAP_BASE;
            cfg_reg.safe_limit       <= rtvs_pkg::RST_SAFE_LIMIT;
            cfg_reg.button_threshold <= rtvs_pkg::RST_BUTTON_THRESHOLD;
            cfg_reg.hold_ms          <= rtvs_pkg::RST_HOLD_MS;
            cfg_reg.settle_ms        <= rtvs_pkg::RST_SETTLE_MS;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Sample filtering, peak windows and the measure-input, measure-output cycle.
    rtvs_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .adc      (adc),
        .cfg      (cfg_reg),
        .q_full   (q_full),
        .push     (q_push),
        .push_job (q_in_job)
    );

    // Completed output measurements waiting for the sequencer.
    rtvs_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (q_in_job),
        .pop      (q_pop),
        .full     (q_full),
        .empty    (q_empty),
        .head     (q_head)
    );

    // Decision making and one action transaction per clock on act while act is ready.
    rtvs_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .q_empty (q_empty),
        .head    (q_head),
        .pop     (q_pop),
        .act     (act)
    );

endmodule

[rtl/rtvs_front.sv]
// Front end: sample filtering, window peak tracking and measurement sequencing.
module rtvs_front (
    input  logic               clk,
    input  logic               rst_n,
    rtvs_in_if.sink            adc,
    input  rtvs_pkg::cfg_t     cfg,
    input  logic               q_full,
    output logic               push,
    output rtvs_pkg::job_t     push_job
);

    rtvs_pkg::phase_t                phase_reg, phase_next;
    logic [rtvs_pkg::COUNT_W-1:0]    count_reg, count_next;
    logic [rtvs_pkg::INDEX_W-1:0]    index_reg, index_next;
    logic [rtvs_pkg::SAMPLE_W-1:0]   peak_reg, peak_next;
    logic [rtvs_pkg::SUM_W-1:0]      sum_reg, sum_next;
    logic [rtvs_pkg::SUM_W-1:0]      in_sum_reg, in_sum_next;

    logic                            take;
    logic [rtvs_pkg::SAMPLE_W-1:0]   peak_max;
    logic [rtvs_pkg::SUM_W-1:0]      total;
    logic                            window_end;
    logic                            meas_end;
    logic                            in_ok;

    assign adc.ready = !q_full;

    always_comb
    begin
        take       = adc.valid && adc.ready && (adc.channel == (phase_reg != rtvs_pkg::PH_IN));
        peak_max   = (adc.sample > peak_reg) ? adc.sample : peak_reg;
        total      = sum_reg + rtvs_pkg::SUM_W'(peak_max);
        window_end = (count_reg == rtvs_pkg::COUNT_W'(rtvs_pkg::WINDOW_SAMPLES - 1));
        meas_end   = window_end && (index_reg == rtvs_pkg::INDEX_W'(rtvs_pkg::WINDOWS - 1));

        // mean - offset < limit is the same as sum < WINDOWS * (limit + offset).
        in_ok = rtvs_pkg::LIMIT_W'(in_sum_reg) <
                rtvs_pkg::LIMIT_W'(rtvs_pkg::WINDOWS) *
                (rtvs_pkg::LIMIT_W'(cfg.input_limit) +
                 rtvs_pkg::LIMIT_W'(rtvs_pkg::VOLT_OFFSET));

        phase_next  = phase_reg;
        count_next  = count_reg;
        index_next  = index_reg;
        peak_next   = peak_reg;
        sum_next    = sum_reg;
        in_sum_next = in_sum_reg;
        push        = 1'b0;

        push_job.kind       = (phase_reg == rtvs_pkg::PH_OUT2) ? rtvs_pkg::JOB_FINAL
                                                               : rtvs_pkg::JOB_CHECK;
        push_job.in_ok      = in_ok;
        push_job.in_sum     = in_sum_reg;
        push_job.out_sum    = total;
        push_job.button_raw = adc.button_raw;

        if (take)
        begin
            if (!window_end)
            begin
                count_next = count_reg + 1'b1;
                peak_next  = peak_max;
            end
            else
            begin
                count_next = '0;
                peak_next  = '0;
                if (!meas_end)
                begin
                    index_next = index_reg + 1'b1;
                    sum_next   = total;
                end
                else
                begin
                    index_next = '0;
                    sum_next   = '0;
                    unique case (phase_reg)
                        rtvs_pkg::PH_IN:
                        begin
                            in_sum_next = total;
                            phase_next  = rtvs_pkg::PH_OUT1;
                        end
                        rtvs_pkg::PH_OUT1:
                        begin
                            push       = 1'b1;
                            phase_next = in_ok ? rtvs_pkg::PH_OUT2 : rtvs_pkg::PH_IN;
                        end
                        rtvs_pkg::PH_OUT2:
                        begin
                            push       = 1'b1;
                            phase_next = rtvs_pkg::PH_IN;
                        end
                        default:
                        begin
                            phase_next = rtvs_pkg::PH_IN;
                        end
                    endcase
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= rtvs_pkg::PH_IN;
            count_reg  <= '0;
            index_reg  <= '0;
            peak_reg   <= '0;
            sum_reg    <= '0;
            in_sum_reg <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            count_reg  <= count_next;
            index_reg  <= index_next;
            peak_reg   <= peak_next;
            sum_reg    <= sum_next;
            in_sum_reg <= in_sum_next;
        end
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg < rtvs_pkg::COUNT_W'(rtvs_pkg::WINDOW_SAMPLES))
        else $error("window sample count out of range");

    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        index_reg < rtvs_pkg::INDEX_W'(rtvs_pkg::WINDOWS))
        else $error("window index out of range");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_full)
        else $error("measurement pushed into a full queue");

endmodule

[rtl/rtvs_queue.sv]
// Short job queue between the measurement front end and the action sequencer.
module rtvs_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  rtvs_pkg::job_t     push_job,
    input  logic               pop,
    output logic               full,
    output logic               empty,
    output rtvs_pkg::job_t     head
);

    rtvs_pkg::job_t                 entries [rtvs_pkg::QDEPTH];
    logic [rtvs_pkg::QPTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [rtvs_pkg::QPTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [rtvs_pkg::QCNT_W-1:0]    count_reg, count_next;
    logic                           do_push;
    logic                           do_pop;

    always_comb
    begin
        full    = (count_reg == rtvs_pkg::QCNT_W'(rtvs_pkg::QDEPTH));
        empty   = (count_reg == '0);
        head    = entries[rd_ptr_reg];
        do_push = push && !full;
        do_pop  = pop && !empty;

        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == rtvs_pkg::QPTR_W'(rtvs_pkg::QDEPTH - 1)) ? '0
                          : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == rtvs_pkg::QPTR_W'(rtvs_pkg::QDEPTH - 1)) ? '0
                          : rd_ptr_reg + 1'b1;
        end

        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[rtl/rtvs_back.sv]
// Back end: turns a completed output measurement into relay, LED and output actions.
module rtvs_back (
    input  logic               clk,
    input  logic               rst_n,
    input  rtvs_pkg::cfg_t     cfg,
    input  logic               q_empty,
    input  rtvs_pkg::job_t     head,
    output logic               pop,
    rtvs_out_if.source         act
);

    rtvs_pkg::back_state_t             state_reg, state_next;
    rtvs_pkg::job_t                    job_reg, job_next;
    logic [rtvs_pkg::SAMPLE_W-1:0]     in_q_reg, in_q_next;
    logic [rtvs_pkg::SAMPLE_W-1:0]     out_q_reg, out_q_next;
    logic [rtvs_pkg::SAMPLE_W-1:0]     safe_q_reg, safe_q_next;
    logic [rtvs_pkg::NUM_RELAYS-1:0]   relay_reg, relay_next;
    logic                              allowed_reg, allowed_next;
    logic [rtvs_pkg::SLOTS-1:0]        mask_reg, mask_next;
    rtvs_pkg::action_t                 slot_reg [rtvs_pkg::SLOTS];
    rtvs_pkg::action_t                 slot_next [rtvs_pkg::SLOTS];
    logic                              out_valid_reg, out_valid_next;
    rtvs_pkg::action_t                 out_act_reg, out_act_next;
    logic                              out_last_reg, out_last_next;

    logic [rtvs_pkg::PROD_W-1:0]       in_prod;
    logic [rtvs_pkg::PROD_W-1:0]       out_prod;
    logic [rtvs_pkg::PROD_W-1:0]       safe_prod;
    logic                              reselect;
    logic [rtvs_pkg::SAMPLE_W:0]       tap_floor;
    logic [rtvs_pkg::SAMPLE_W-1:0]     tap_diff;
    logic [2:0]                        tap;
    logic [2:0]                        tap_code;
    logic [rtvs_pkg::NUM_RELAYS-1:0]   goal;
    logic                              safe_ok;
    logic                              button_hit;
    logic [rtvs_pkg::WAIT_W-1:0]       settle;
    logic [rtvs_pkg::SLOT_W-1:0]       sel;
    logic [rtvs_pkg::SLOTS-1:0]        sel_hot;
    logic                              out_free;
    logic [1:0]                        r;

    assign act.valid   = out_valid_reg;
    assign act.target  = out_act_reg.target;
    assign act.level   = out_act_reg.level;
    assign act.wait_ms = out_act_reg.wait_ms;
    assign act.last    = out_last_reg;

    always_comb
    begin
        // Quotients by reciprocal multiplication, registered before use.
        in_prod   = rtvs_pkg::PROD_W'(head.in_sum) * rtvs_pkg::PROD_W'(rtvs_pkg::WIN_RECIP);
        out_prod  = rtvs_pkg::PROD_W'(head.out_sum) * rtvs_pkg::PROD_W'(rtvs_pkg::WIN_RECIP);
        safe_prod = rtvs_pkg::PROD_W'(cfg.safe_limit) *
                    rtvs_pkg::PROD_W'(rtvs_pkg::SAFE_RECIP);

        settle = rtvs_pkg::WAIT_W'(cfg.settle_ms);

        // Band test in the offset domain: volts > high is mean > high + offset.
        reselect = ((rtvs_pkg::SAMPLE_W+1)'(out_q_reg) >
                    (rtvs_pkg::SAMPLE_W+1)'(cfg.band_high) +
                    (rtvs_pkg::SAMPLE_W+1)'(rtvs_pkg::VOLT_OFFSET)) ||
                   ((rtvs_pkg::SAMPLE_W+1)'(out_q_reg) <
                    (rtvs_pkg::SAMPLE_W+1)'(cfg.band_low) +
                    (rtvs_pkg::SAMPLE_W+1)'(rtvs_pkg::VOLT_OFFSET));

        // Tap is the clamped excess over the base, in steps, saturated.
        tap_floor = (rtvs_pkg::SAMPLE_W+1)'(rtvs_pkg::VOLT_OFFSET) +
                    (rtvs_pkg::SAMPLE_W+1)'(cfg.tap_base);
        tap_diff  = ((rtvs_pkg::SAMPLE_W+1)'(in_q_reg) >= tap_floor) ?
                    rtvs_pkg::SAMPLE_W'((rtvs_pkg::SAMPLE_W+1)'(in_q_reg) - tap_floor) : '0;
        tap = '0;
        for (int k = 1; k <= rtvs_pkg::TAP_MAX; k++)
        begin
            if (tap_diff >= rtvs_pkg::SAMPLE_W'(k * rtvs_pkg::TAP_STEP))
            begin
                tap = tap + 3'd1;
            end
        end
        tap_code = rtvs_pkg::TAP_MAP[tap];
        goal     = {tap_code[0], tap_code[1], tap_code[2]};

        // Truncating division of a negative voltage gives at most zero, so the
        // safe test reduces to volts <= 3 * (limit / 3) + 2 in every case.
        safe_ok = (12'(out_q_reg) <=
                   12'(safe_q_reg) * 12'(rtvs_pkg::SAFE_DIV) +
                   12'(rtvs_pkg::VOLT_OFFSET + rtvs_pkg::SAFE_DIV - 1));

        button_hit = job_reg.button_raw > cfg.button_threshold;

        out_free = !out_valid_reg || act.ready;

        sel     = '0;
        for (int i = rtvs_pkg::SLOTS - 1; i >= 0; i--)
        begin
            if (mask_reg[i])
            begin
                sel = rtvs_pkg::SLOT_W'(i);
            end
        end
        sel_hot = rtvs_pkg::SLOTS'(1) << sel;

        state_next     = state_reg;
        job_next       = job_reg;
        in_q_next      = in_q_reg;
        out_q_next     = out_q_reg;
        safe_q_next    = safe_q_reg;
        relay_next     = relay_reg;
        allowed_next   = allowed_reg;
        mask_next      = mask_reg;
        out_valid_next = out_valid_reg && !act.ready;
        out_act_next   = out_act_reg;
        out_last_next  = out_last_reg;
        pop            = 1'b0;
        r              = '0;
        for (int i = 0; i < rtvs_pkg::SLOTS; i++)
        begin
            slot_next[i] = slot_reg[i];
        end

        unique case (state_reg)
            rtvs_pkg::B_IDLE:
            begin
                if (!q_empty)
                begin
                    pop         = 1'b1;
                    job_next    = head;
                    in_q_next   = in_prod[rtvs_pkg::RECIP_SHIFT +: rtvs_pkg::SAMPLE_W];
                    out_q_next  = out_prod[rtvs_pkg::RECIP_SHIFT +: rtvs_pkg::SAMPLE_W];
                    safe_q_next = safe_prod[rtvs_pkg::RECIP_SHIFT +: rtvs_pkg::SAMPLE_W];
                    state_next  = rtvs_pkg::B_PLAN;
                end
            end
            rtvs_pkg::B_PLAN:
            begin
                mask_next = '0;
                for (int i = 0; i < rtvs_pkg::SLOTS; i++)
                begin
                    slot_next[i] = '0;
                end
                unique case (job_reg.kind)
                    rtvs_pkg::JOB_CHECK:
                    begin
                        if (job_reg.in_ok)
                        begin
                            slot_next[0].target  = rtvs_pkg::TGT_DELAY_LED;
                            slot_next[0].level   = 1'b1;
                            slot_next[0].wait_ms = cfg.hold_ms;
                            slot_next[1].target  = rtvs_pkg::TGT_DELAY_LED;
                            slot_next[1].level   = 1'b0;
                            slot_next[1].wait_ms = '0;
                            mask_next[0] = !allowed_reg && button_hit;
                            mask_next[1] = !allowed_reg && button_hit;
                            if (reselect)
                            begin
                                for (int k = 0; k < rtvs_pkg::NUM_RELAYS; k++)
                                begin
                                    r = rtvs_pkg::RELAY_ORDER[k];
                                    slot_next[2 + k].target  = rtvs_pkg::TARGET_W'(r);
                                    slot_next[2 + k].level   = 1'b1;
                                    slot_next[2 + k].wait_ms = settle;
                                    mask_next[2 + k] = goal[r] && !relay_reg[r];
                                    slot_next[2 + rtvs_pkg::NUM_RELAYS + k].target =
                                        rtvs_pkg::TARGET_W'(r);
                                    slot_next[2 + rtvs_pkg::NUM_RELAYS + k].level   = 1'b0;
                                    slot_next[2 + rtvs_pkg::NUM_RELAYS + k].wait_ms = settle;
                                    mask_next[2 + rtvs_pkg::NUM_RELAYS + k] =
                                        !goal[r] && relay_reg[r];
                                end
                                relay_next = goal;
                            end
                        end
                        else
                        begin
                            allowed_next         = 1'b0;
                            slot_next[0].target  = rtvs_pkg::TGT_OUTPUT;
                            slot_next[0].level   = 1'b0;
                            slot_next[0].wait_ms = settle;
                            slot_next[1].target  = rtvs_pkg::TGT_PROT_LED;
                            slot_next[1].level   = 1'b1;
                            slot_next[1].wait_ms = '0;
                            mask_next[1:0]       = 2'b11;
                        end
                    end
                    rtvs_pkg::JOB_FINAL:
                    begin
                        allowed_next         = safe_ok;
                        slot_next[0].target  = rtvs_pkg::TGT_OUTPUT;
                        slot_next[0].level   = safe_ok;
                        slot_next[0].wait_ms = settle;
                        slot_next[1].target  = rtvs_pkg::TGT_PROT_LED;
                        slot_next[1].level   = !safe_ok;
                        slot_next[1].wait_ms = '0;
                        mask_next[1:0]       = 2'b11;
                    end
                    default:
                    begin
                        mask_next = '0;
                    end
                endcase
                state_next = rtvs_pkg::B_EMIT;
            end
            rtvs_pkg::B_EMIT:
            begin
                if (mask_reg == '0)
                begin
                    state_next = rtvs_pkg::B_IDLE;
                end
                else if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_act_next   = slot_reg[sel];
                    mask_next      = mask_reg & ~sel_hot;
                    out_last_next  = ((mask_reg & ~sel_hot) == '0);
                    if ((mask_reg & ~sel_hot) == '0)
                    begin
                        state_next = rtvs_pkg::B_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = rtvs_pkg::B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        job_reg     <= job_next;
        in_q_reg    <= in_q_next;
        out_q_reg   <= out_q_next;
        safe_q_reg  <= safe_q_next;
        out_act_reg <= out_act_next;
        out_last_reg <= out_last_next;
        for (int i = 0; i < rtvs_pkg::SLOTS; i++)
        begin
            slot_reg[i] <= slot_next[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rtvs_pkg::B_IDLE;
            relay_reg     <= rtvs_pkg::RELAY_RESET;
            allowed_reg   <= 1'b0;
            mask_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            relay_reg     <= relay_next;
            allowed_reg   <= allowed_next;
            mask_reg      <= mask_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_mask_only_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != rtvs_pkg::B_EMIT) |-> (mask_reg == '0))
        else $error("pending actions outside the emit state");

    a_relay_pattern: assert property (@(posedge clk) disable iff (!rst_n)
        (relay_reg != 3'b011) && (relay_reg != 3'b111))
        else $error("relay levels match no tap");

    a_load_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == rtvs_pkg::B_EMIT))
        else $error("action loaded outside the emit state");

endmodule

[tb/sv/relay_tap_voltage_stabilizer_top_test.sv]
// Self-checking testbench for the relay tap voltage stabilizer top level.
`timescale 1ns / 1ps

module relay_tap_voltage_stabilizer_top_test;

    // A measurement is the mean of the window peaks minus this offset.
    localparam int ADC_OFFSET = 432;

    // Cycles allowed after the last expected action before the block is taken
    // as idle. The first action trails its completing sample by the queue and
    // the back end registers, and a quiet completion leaves none to wait for.
    localparam int HOLD_OFF_CYCLES = 16;

    // Cycles without any transaction on either channel before the run is
    // declared hung.
    localparam int STALL_LIMIT = 5000;

    // Relay targets are the relay numbers themselves.
    localparam logic [rtvs_pkg::TARGET_W-1:0] TGT_RELAY1 = 3'd1;

    // Relay pattern closed by each tap (bit i drives relay i), and the order
    // in which the relays are visited during each switching pass.
    localparam logic [2:0] TAP_RELAYS [6] = '{3'd0, 3'd4, 3'd1, 3'd5, 3'd2, 3'd6};
    localparam int RELAY_VISIT [3] = '{1, 0, 2};

    typedef struct packed {
        logic [rtvs_pkg::TARGET_W-1:0] target;
        logic                          level;
        logic [rtvs_pkg::WAIT_W-1:0]   wait_ms;
        logic                          last;
    } exp_action_t;

    // How a directed row is checked: by the predictor, or against a fixed
    // sequence that is plain from the reset settings.
    typedef enum logic [1:0] {
        CHK_PREDICTED,
        CHK_SHUTDOWN,
        CHK_DELAY_DROP
    } check_kind_t;

    typedef struct packed {
        logic        ch;
        logic [9:0]  p0;
        logic [9:0]  p1;
        logic [9:0]  p2;
        logic [9:0]  btn;
        check_kind_t chk;
    } row_t;

    // Directed measurements under the reset settings. Each row is one full
    // measurement whose three windows peak at p0, p1 and p2; btn is the button
    // reading carried by the completing sample.
    localparam row_t DIRECTED [23] = '{
        // Highest input, then an output measurement that must shut down.
        '{1'b0, 10'd1023, 10'd1023, 10'd1023, 10'd0,    CHK_PREDICTED},
        '{1'b1, 10'd0,    10'd0,    10'd0,    10'd1023, CHK_SHUTDOWN},
        // Output channel while the input is being measured: all ignored.
        '{1'b1, 10'd1023, 10'd1023, 10'd1023, 10'd1023, CHK_PREDICTED},
        // Most negative input, then delay button and a drop to tap 0.
        '{1'b0, 10'd0,    10'd0,    10'd0,    10'd0,    CHK_PREDICTED},
        '{1'b1, 10'd1023, 10'd1023, 10'd1023, 10'd1023, CHK_DELAY_DROP},
        '{1'b1, 10'd1023, 10'd1023, 10'd1023, 10'd0,    CHK_SHUTDOWN},
        // Input just under the limit, output just over the band, button at
        // the threshold, output just inside the safe limit.
        '{1'b0, 10'd690,  10'd690,  10'd690,  10'd0,    CHK_PREDICTED},
        '{1'b1, 10'd676,  10'd676,  10'd676,  10'd350,  CHK_PREDICTED},
        '{1'b1, 10'd678,  10'd678,  10'd678,  10'd0,    CHK_PREDICTED},
        // Uneven peaks; output on the band edge gives a quiet completion even
        // with the button pressed, since the output is already allowed.
        '{1'b0, 10'd690,  10'd691,  10'd691,  10'd0,    CHK_PREDICTED},
        '{1'b1, 10'd649,  10'd649,  10'd649,  10'd351,  CHK_PREDICTED},
        '{1'b1, 10'd681,  10'd681,  10'd681,  10'd0,    CHK_PREDICTED},
        // Input exactly at the limit.
        '{1'b0, 10'd691,  10'd691,  10'd691,  10'd0,    CHK_PREDICTED},
        '{1'b1, 10'd660,  10'd660,  10'd660,  10'd1023, CHK_SHUTDOWN},
        // Output under the band with the button pressed.
        '{1'b0, 10'd632,  10'd632,  10'd632,  10'd0,    CHK_PREDICTED},
        '{1'b1, 10'd648,  10'd648,  10'd648,  10'd351,  CHK_PREDICTED},
        '{1'b1, 10'd0,    10'd0,    10'd0,    10'd0,    CHK_PREDICTED},
        // Output on the upper band edge, then small negative outputs.
        '{1'b0, 10'd619,  10'd619,  10'd619,  10'd0,    CHK_PREDICTED},
        '{1'b1, 10'd675,  10'd675,  10'd675,  10'd0,    CHK_PREDICTED},
        '{1'b1, 10'd430,  10'd430,  10'd430,  10'd0,    CHK_PREDICTED},
        '{1'b0, 10'd432,  10'd432,  10'd432,  10'd0,    CHK_PREDICTED},
        '{1'b1, 10'd1023, 10'd1023, 10'd1023, 10'd1023, CHK_PREDICTED},
        '{1'b1, 10'd431,  10'd431,  10'd431,  10'd0,    CHK_PREDICTED}
    };

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [rtvs_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [rtvs_pkg::CFG_DATA_W-1:0] cfg_data;

    rtvs_in_if  adc_bus ();
    rtvs_out_if act_bus ();

    relay_tap_voltage_stabilizer_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .adc       (adc_bus),
        .act       (act_bus),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Settings as the block should hold them.
    int lim_input;
    int lim_band_high;
    int lim_band_low;
    int tap_floor;
    int lim_safe;
    int btn_threshold;
    int hold_len;
    int settle_len;

    // Measurement and relay state as the block should hold it.
    rtvs_pkg::phase_t meter_phase;
    int               win_count;
    int               win_index;
    int               win_peak;
    int               peak_sum;
    int               line_in_volts;
    logic             out_allowed;
    logic [2:0]       relay_state;

    // Actions that the block still owes, oldest first.
    exp_action_t expected_actions[$];
    // Actions caused by the sample just accepted.
    exp_action_t step_actions[$];
    // Fixed sequence that replaces the prediction for a directed row.
    exp_action_t fixed_actions[$];

    int actions_planned = 0;
    int failures = 0;
    int src_idle_pct = 0;
    int act_stall_pct = 0;
    int quiet_cycles = 0;
    exp_action_t head;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Receiver side: stall at random according to the current stage.
    always @(negedge clk)
    begin
        act_bus.ready <= ($urandom_range(0, 99) >= act_stall_pct);
    end

    // Compare each action transaction with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && act_bus.valid && act_bus.ready)
        begin
            if (expected_actions.size() == 0)
            begin
                $error("unexpected action: target %0d level %0d wait_ms %0d last %0d",
                       act_bus.target, act_bus.level, act_bus.wait_ms, act_bus.last);
                failures++;
            end
            else
            begin
                head = expected_actions.pop_front();
                if (act_bus.target !== head.target)
                begin
                    $error("target: expected %0d, got %0d", head.target, act_bus.target);
                    failures++;
                end
                if (act_bus.level !== head.level)
                begin
                    $error("level: expected %0d, got %0d", head.level, act_bus.level);
                    failures++;
                end
                if (act_bus.wait_ms !== head.wait_ms)
                begin
                    $error("wait_ms: expected %0d, got %0d", head.wait_ms, act_bus.wait_ms);
                    failures++;
                end
                if (act_bus.last !== head.last)
                begin
                    $error("last: expected %0d, got %0d", head.last, act_bus.last);
                    failures++;
                end
            end
        end
    end

    // Watchdog: a long stretch with no transaction on either channel means the
    // block has hung.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((adc_bus.valid && adc_bus.ready) || (act_bus.valid && act_bus.ready))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
                if (quiet_cycles >= STALL_LIMIT)
                begin
                    $display("status: fail");
                    $finish;
                end
            end
        end
    end

    function automatic void add_action(logic [rtvs_pkg::TARGET_W-1:0] tgt, logic lvl, int w);
        exp_action_t a;
        a.target  = tgt;
        a.level   = lvl;
        a.wait_ms = w[rtvs_pkg::WAIT_W-1:0];
        a.last    = 1'b0;
        step_actions.push_back(a);
    endfunction

    // One switching pass: visit the relays in their fixed order and move those
    // that should end at the given level and are not there yet.
    function automatic void switch_pass(logic [2:0] goal, logic lvl);
        int r;
        for (int k = 0; k < 3; k++)
        begin
            r = RELAY_VISIT[k];
            if (goal[r] == lvl && relay_state[r] != lvl)
            begin
                relay_state[r] = lvl;
                add_action(r[rtvs_pkg::TARGET_W-1:0], lvl, settle_len);
            end
        end
    endfunction

    // Advance the peak meter by one accepted sample and collect the actions it
    // causes into step_actions.
    function automatic void meter_sample(logic [9:0] smp, logic ch, logic [9:0] btn);
        int volts;
        int over;
        int tap;
        step_actions.delete();
        if (meter_phase != rtvs_pkg::PH_OUT1 && meter_phase != rtvs_pkg::PH_OUT2)
            meter_phase = rtvs_pkg::PH_IN;
        // The input line is measured first, the output line in both later
        // phases; the other channel is dropped.
        if (ch != (meter_phase != rtvs_pkg::PH_IN))
            return;
        if (smp > win_peak)
            win_peak = smp;
        win_count++;
        if (win_count < rtvs_pkg::WINDOW_SAMPLES)
            return;
        win_count = 0;
        peak_sum += win_peak;
        win_peak = 0;
        win_index++;
        if (win_index < rtvs_pkg::WINDOWS)
            return;
        win_index = 0;
        volts = peak_sum / rtvs_pkg::WINDOWS - ADC_OFFSET;
        peak_sum = 0;

        case (meter_phase)
            rtvs_pkg::PH_IN:
            begin
                line_in_volts = volts;
                meter_phase = rtvs_pkg::PH_OUT1;
            end
            rtvs_pkg::PH_OUT1:
            begin
                if (line_in_volts < lim_input)
                begin
                    if (!out_allowed && btn > btn_threshold)
                    begin
                        add_action(rtvs_pkg::TGT_DELAY_LED, 1'b1, hold_len);
                        add_action(rtvs_pkg::TGT_DELAY_LED, 1'b0, 0);
                    end
                    if (volts > lim_band_high || volts < lim_band_low)
                    begin
                        over = line_in_volts - tap_floor;
                        if (over < 0)
                            over = 0;
                        tap = over / 20;
                        if (tap > 5)
                            tap = 5;
                        // Turn-ons first so the transformer is never left open.
                        switch_pass(TAP_RELAYS[tap], 1'b1);
                        switch_pass(TAP_RELAYS[tap], 1'b0);
                    end
                    meter_phase = rtvs_pkg::PH_OUT2;
                end
                else
                begin
                    out_allowed = 1'b0;
                    add_action(rtvs_pkg::TGT_OUTPUT, 1'b0, settle_len);
                    add_action(rtvs_pkg::TGT_PROT_LED, 1'b1, 0);
                    meter_phase = rtvs_pkg::PH_IN;
                end
            end
            default:
            begin
                // Both quotients truncate toward zero, which matters for
                // small negative outputs.
                out_allowed = (volts / 3 <= lim_safe / 3);
                add_action(rtvs_pkg::TGT_OUTPUT, out_allowed, settle_len);
                add_action(rtvs_pkg::TGT_PROT_LED, !out_allowed, 0);
                meter_phase = rtvs_pkg::PH_IN;
            end
        endcase

        if (step_actions.size() != 0)
            step_actions[step_actions.size() - 1].last = 1'b1;
    endfunction

    function automatic int peak_of(int v);
        if (v < 0)
            return 0;
        if (v > rtvs_pkg::SAMPLE_MAX)
            return rtvs_pkg::SAMPLE_MAX;
        return v;
    endfunction

    // Pick a voltage for the next measurement that lands near whatever
    // decision the current phase is about to make.
    function automatic int pick_volts();
        int pick;
        pick = $urandom_range(0, 3);
        if (meter_phase == rtvs_pkg::PH_IN)
        begin
            case (pick)
                0: return lim_input + int'($urandom_range(0, 4)) - 2;
                1: return tap_floor + int'($urandom_range(0, 130));
                2: return lim_input - 1 - int'($urandom_range(0, 40));
                default: return int'($urandom_range(0, rtvs_pkg::SAMPLE_MAX)) - ADC_OFFSET;
            endcase
        end
        else if (meter_phase == rtvs_pkg::PH_OUT1)
        begin
            case (pick)
                0: return lim_band_high + int'($urandom_range(0, 4)) - 2;
                1: return lim_band_low + int'($urandom_range(0, 4)) - 2;
                2: return lim_band_low + int'($urandom_range(0, 60));
                default: return int'($urandom_range(0, rtvs_pkg::SAMPLE_MAX)) - ADC_OFFSET;
            endcase
        end
        else
        begin
            case (pick)
                0: return lim_safe + int'($urandom_range(0, 8)) - 4;
                1: return -int'($urandom_range(0, 5));
                default: return int'($urandom_range(0, rtvs_pkg::SAMPLE_MAX)) - ADC_OFFSET;
            endcase
        end
    endfunction

    // Offer one sample transaction; entered and left at a falling edge.
    task automatic send_sample(logic [9:0] smp, logic ch, logic [9:0] btn);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            adc_bus.valid <= 1'b0;
            @(negedge clk);
        end
        adc_bus.valid      <= 1'b1;
        adc_bus.sample     <= smp;
        adc_bus.channel    <= ch;
        adc_bus.button_raw <= btn;
        @(posedge clk);
        while (!adc_bus.ready)
            @(posedge clk);
        meter_sample(smp, ch, btn);
        if (fixed_actions.size() != 0 && step_actions.size() != 0)
        begin
            step_actions = fixed_actions;
            fixed_actions.delete();
        end
        foreach (step_actions[i])
            expected_actions.push_back(step_actions[i]);
        actions_planned += step_actions.size();
        @(negedge clk);
    endtask

    // One full measurement on channel ch: three windows with the given peaks,
    // with stray samples for the other channel mixed in at noise_pct.
    task automatic send_measurement(logic ch, int p0, int p1, int p2, int last_btn,
                                    int noise_pct);
        int peaks [3];
        int spot;
        int s;
        int b;
        peaks = '{p0, p1, p2};
        for (int w = 0; w < rtvs_pkg::WINDOWS; w++)
        begin
            spot = $urandom_range(0, rtvs_pkg::WINDOW_SAMPLES - 1);
            for (int i = 0; i < rtvs_pkg::WINDOW_SAMPLES; i++)
            begin
                if ($urandom_range(0, 99) < noise_pct)
                    send_sample(10'($urandom_range(0, rtvs_pkg::SAMPLE_MAX)), !ch,
                                10'($urandom_range(0, rtvs_pkg::SAMPLE_MAX)));
                s = (i == spot) ? peaks[w] : $urandom_range(0, peaks[w]);
                b = (w == rtvs_pkg::WINDOWS - 1 && i == rtvs_pkg::WINDOW_SAMPLES - 1)
                    ? last_btn : $urandom_range(0, rtvs_pkg::SAMPLE_MAX);
                send_sample(10'(s), ch, 10'(b));
            end
        end
    endtask

    // Stop offering samples until every owed action has come out, then give
    // the block time to finish a completion that yields nothing.
    task automatic hold_for_results();
        adc_bus.valid <= 1'b0;
        while (expected_actions.size() != 0)
            @(negedge clk);
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
    endtask

    // Write one register. The narrow registers get random upper data bits,
    // which the block must ignore.
    task automatic write_reg(logic [rtvs_pkg::CFG_IDX_W-1:0] idx, int unsigned value);
        logic [rtvs_pkg::CFG_DATA_W-1:0] data;
        data = {6'($urandom_range(0, 63)), value[9:0]};
        if (idx == rtvs_pkg::REG_HOLD_MS)
            data = value[15:0];
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            rtvs_pkg::REG_INPUT_LIMIT:      lim_input     = value[9:0];
            rtvs_pkg::REG_BAND_HIGH:        lim_band_high = value[9:0];
            rtvs_pkg::REG_BAND_LOW:         lim_band_low  = value[9:0];
            rtvs_pkg::REG_TAP_BASE:         tap_floor     = value[9:0];
            rtvs_pkg::REG_SAFE_LIMIT:       lim_safe      = value[9:0];
            rtvs_pkg::REG_BUTTON_THRESHOLD: btn_threshold = value[9:0];
            rtvs_pkg::REG_HOLD_MS:          hold_len      = value[15:0];
            default:                        settle_len    = value[9:0];
        endcase
        @(negedge clk);
    endtask

    task automatic program_settings(int il, int bh, int bl, int tb, int sl, int bt,
                                    int hd, int st);
        write_reg(rtvs_pkg::REG_INPUT_LIMIT, il);
        write_reg(rtvs_pkg::REG_BAND_HIGH, bh);
        write_reg(rtvs_pkg::REG_BAND_LOW, bl);
        write_reg(rtvs_pkg::REG_TAP_BASE, tb);
        write_reg(rtvs_pkg::REG_SAFE_LIMIT, sl);
        write_reg(rtvs_pkg::REG_BUTTON_THRESHOLD, bt);
        write_reg(rtvs_pkg::REG_HOLD_MS, hd);
        write_reg(rtvs_pkg::REG_SETTLE_MS, st);
        cfg_we <= 1'b0;
    endtask

    // At least six random rounds, until the stage has owed at least want actions.
    // Most are well-formed measurements aimed at the next decision; some are
    // bursts of raw samples that knock the windows out of step.
    task automatic random_stage(int want);
        int start;
        int count;
        int v;
        int b;
        start = actions_planned;
        count = 0;
        while (actions_planned - start < want || count < 6)
        begin
            count++;
            if ($urandom_range(0, 11) == 0)
                hold_for_results();
            if ($urandom_range(0, 9) == 0)
            begin
                repeat ($urandom_range(1, 400))
                    send_sample(10'($urandom_range(0, rtvs_pkg::SAMPLE_MAX)),
                                1'($urandom_range(0, 1)),
                                10'($urandom_range(0, rtvs_pkg::SAMPLE_MAX)));
            end
            else
            begin
                v = pick_volts() + ADC_OFFSET;
                if ($urandom_range(0, 1) != 0)
                    b = peak_of(btn_threshold + int'($urandom_range(0, 2)) - 1);
                else
                    b = $urandom_range(0, rtvs_pkg::SAMPLE_MAX);
                send_measurement(meter_phase != rtvs_pkg::PH_IN,
                                 peak_of(v + int'($urandom_range(0, 2)) - 1),
                                 peak_of(v + int'($urandom_range(0, 2)) - 1),
                                 peak_of(v + int'($urandom_range(0, 2)) - 1),
                                 b, 10);
            end
        end
    endtask

    initial
    begin
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = rtvs_pkg::REG_INPUT_LIMIT;
        cfg_data           = '0;
        adc_bus.valid      = 1'b0;
        adc_bus.sample     = '0;
        adc_bus.channel    = 1'b0;
        adc_bus.button_raw = '0;
        act_bus.ready      = 1'b0;

        lim_input     = rtvs_pkg::RST_INPUT_LIMIT;
        lim_band_high = rtvs_pkg::RST_BAND_HIGH;
        lim_band_low  = rtvs_pkg::RST_BAND_LOW;
        tap_floor     = rtvs_pkg::RST_TAP_BASE;
        lim_safe      = rtvs_pkg::RST_SAFE_LIMIT;
        btn_threshold = rtvs_pkg::RST_BUTTON_THRESHOLD;
        hold_len      = rtvs_pkg::RST_HOLD_MS;
        settle_len    = rtvs_pkg::RST_SETTLE_MS;
        meter_phase   = rtvs_pkg::PH_IN;
        win_count     = 0;
        win_index     = 0;
        win_peak      = 0;
        peak_sum      = 0;
        line_in_volts = 0;
        out_allowed   = 1'b0;
        relay_state   = rtvs_pkg::RELAY_RESET;

        // First stage: the sender idles now and then, the receiver mostly.
        src_idle_pct  = 34;
        act_stall_pct = 86;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed measurements under the reset settings.
        foreach (DIRECTED[r])
        begin
            fixed_actions.delete();
            case (DIRECTED[r].chk)
                CHK_SHUTDOWN:
                begin
                    fixed_actions.push_back('{rtvs_pkg::TGT_OUTPUT, 1'b0,
                                              16'(rtvs_pkg::RST_SETTLE_MS), 1'b0});
                    fixed_actions.push_back('{rtvs_pkg::TGT_PROT_LED, 1'b1, 16'd0, 1'b1});
                end
                CHK_DELAY_DROP:
                begin
                    // Delay LED cycle, then tap 0 opens the one relay that
                    // reset leaves closed.
                    fixed_actions.push_back('{rtvs_pkg::TGT_DELAY_LED, 1'b1,
                                              rtvs_pkg::RST_HOLD_MS, 1'b0});
                    fixed_actions.push_back('{rtvs_pkg::TGT_DELAY_LED, 1'b0, 16'd0, 1'b0});
                    fixed_actions.push_back('{TGT_RELAY1, 1'b0,
                                              16'(rtvs_pkg::RST_SETTLE_MS), 1'b1});
                end
                default:
                begin
                end
            endcase
            send_measurement(DIRECTED[r].ch, DIRECTED[r].p0, DIRECTED[r].p1,
                             DIRECTED[r].p2, DIRECTED[r].btn, 0);
            fixed_actions.delete();
        end

        // Upper extremes: output never forbidden by the input, every output
        // outside the band, button pressed at any nonzero reading, longest waits.
        hold_for_results();
        program_settings(1023, 0, 1023, 0, 1023, 0, 65535, 1023);
        random_stage(16);

        // Lower extremes with the idling swapped: only negative inputs pass,
        // zero waits, the button can never count as pressed.
        hold_for_results();
        src_idle_pct  = 86;
        act_stall_pct = 34;
        program_settings(0, 0, 0, 0, 0, 1023, 0, 0);
        random_stage(16);

        // Full rate on both sides: random settings, then the reset values.
        hold_for_results();
        src_idle_pct  = 0;
        act_stall_pct = 0;
        begin
            int bl;
            bl = $urandom_range(150, 300);
            program_settings($urandom_range(150, 400), bl + $urandom_range(0, 60), bl,
                             $urandom_range(0, 300), $urandom_range(0, 1023),
                             $urandom_range(0, 1023), $urandom_range(0, 65535),
                             $urandom_range(0, 1023));
        end
        random_stage(16);
        hold_for_results();
        program_settings(rtvs_pkg::RST_INPUT_LIMIT, rtvs_pkg::RST_BAND_HIGH,
                         rtvs_pkg::RST_BAND_LOW, rtvs_pkg::RST_TAP_BASE,
                         rtvs_pkg::RST_SAFE_LIMIT, rtvs_pkg::RST_BUTTON_THRESHOLD,
                         rtvs_pkg::RST_HOLD_MS, rtvs_pkg::RST_SETTLE_MS);
        random_stage(16);

        hold_for_results();
        if (failures == 0 && expected_actions.size() == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/rtvs_pkg.sv
rtl/rtvs_in_if.sv
rtl/rtvs_out_if.sv
rtl/rtvs_front.sv
rtl/rtvs_queue.sv
rtl/rtvs_back.sv
rtl/relay_tap_voltage_stabilizer_top.sv
tb/sv/relay_tap_voltage_stabilizer_top_test.sv
